/* rtl/core/f64_fmod_pkg.sv */
// ----------------------------------------------------------------------------
// f64_fmod_pkg
// Shared constants and command/status types for the binary64 remainder block.
// ----------------------------------------------------------------------------
package f64_fmod_pkg;

  localparam logic [63:0] SIGN_MASK  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ABS_MASK   = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] INF_BITS   = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT  = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEF_NAN    = 64'h7ff8_0000_0000_0000;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned EXP_W      = 13;

  typedef struct packed {
    logic load;
    logic norm_step;
    logic div_step;
    logic final_sub;
    logic renorm_step;
    logic pack;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic norm_done;
    logic div_done;
    logic renorm_done;
  } status_t;

endpackage

/* rtl/core/f64_fmod_dp.sv */
// ----------------------------------------------------------------------------
// f64_fmod_dp
// Datapath: operand unpack, normalize, restoring division, renormalize, pack.
// ----------------------------------------------------------------------------
module f64_fmod_dp (
  input  logic                                clk_i,
  input  logic [f64_fmod_pkg::DATA_W-1:0]     x_i,
  input  logic [f64_fmod_pkg::DATA_W-1:0]     y_i,
  input  f64_fmod_pkg::cmd_t                  cmd_i,
  output f64_fmod_pkg::status_t               sts_o,
  output logic [f64_fmod_pkg::DATA_W-1:0]     res_o
);

  localparam int unsigned EW = f64_fmod_pkg::EXP_W;

  logic            sign_q, sign_d;
  logic [53:0]     rem_q, rem_d;
  logic [52:0]     den_q, den_d;
  logic [EW-1:0]   xe_q, xe_d, ye_q, ye_d;
  logic            special_q, special_d;
  logic [63:0]     res_q, res_d;
  logic [63:0]     xa, ya;
  logic [53:0]     rem_sub;
  logic [EW-1:0]   sh;

  assign xa = x_i & f64_fmod_pkg::ABS_MASK;
  assign ya = y_i & f64_fmod_pkg::ABS_MASK;
  assign rem_sub = (rem_q >= {1'b0, den_q}) ? rem_q - {1'b0, den_q} : rem_q;
  assign sh = EW'(1) - xe_q;

  always_comb begin
    sign_d = sign_q; rem_d = rem_q; den_d = den_q;
    xe_d = xe_q; ye_d = ye_q; special_d = special_q; res_d = res_q;
    if (cmd_i.load) begin
      sign_d = x_i[63];
      special_d = 1'b1;
      rem_d = {1'b0, (xa[62:52] != 11'd0), xa[51:0]};
      den_d = {(ya[62:52] != 11'd0), ya[51:0]};
      xe_d = (xa[62:52] == 11'd0) ? EW'(1) : EW'(xa[62:52]);
      ye_d = (ya[62:52] == 11'd0) ? EW'(1) : EW'(ya[62:52]);
      if (xa > f64_fmod_pkg::INF_BITS) res_d = x_i | f64_fmod_pkg::QUIET_BIT;
      else if (ya > f64_fmod_pkg::INF_BITS) res_d = y_i | f64_fmod_pkg::QUIET_BIT;
      else if (xa == f64_fmod_pkg::INF_BITS || ya == 64'd0) res_d = f64_fmod_pkg::DEF_NAN;
      else if (xa < ya) res_d = x_i;
      else if (xa == ya) res_d = {x_i[63], 63'd0};
      else special_d = 1'b0;
    end
    if (cmd_i.norm_step) begin
      if (!rem_q[52]) begin
        rem_d = rem_q << 1; xe_d = xe_q - EW'(1);
      end
      if (!den_q[52]) begin
        den_d = den_q << 1; ye_d = ye_q - EW'(1);
      end
    end
    if (cmd_i.div_step) begin
      rem_d = rem_sub << 1; xe_d = xe_q - EW'(1);
    end
    if (cmd_i.final_sub) rem_d = rem_sub;
    if (cmd_i.renorm_step) begin
      rem_d = rem_q << 1; xe_d = xe_q - EW'(1);
    end
    if (cmd_i.pack) begin
      if (rem_q == 54'd0) res_d = {sign_q, 63'd0};
      else if (!xe_q[EW-1] && xe_q != '0)
        res_d = {sign_q, xe_q[10:0], rem_q[51:0]};
      else if (sh >= EW'(64)) res_d = {sign_q, 63'd0};
      else res_d = {sign_q, 63'({10'd0, rem_q} >> sh[5:0])};
    end
  end

  always_ff @(posedge clk_i) begin
    sign_q <= sign_d; rem_q <= rem_d; den_q <= den_d; xe_q <= xe_d;
    ye_q <= ye_d; special_q <= special_d; res_q <= res_d;
  end

  assign sts_o.special     = special_q;
  assign sts_o.norm_done   = rem_q[52] && den_q[52];
  assign sts_o.div_done    = ($signed(xe_q) <= $signed(ye_q));
  assign sts_o.renorm_done = rem_q[52] || rem_q == 54'd0;
  assign res_o = res_q;

endmodule

/* rtl/core/f64_fmod_ctrl.sv */
// ----------------------------------------------------------------------------
// f64_fmod_ctrl
// Controller: sequences load, special check, normalize, divide, renormalize, pack and result hold.
// ----------------------------------------------------------------------------
module f64_fmod_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  f64_fmod_pkg::status_t sts_i,
  output f64_fmod_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_REN  = 3'd4;
  localparam logic [2:0] S_PACK = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1; state_d = S_CHK;
        end
      end
      S_CHK: state_d = sts_i.special ? S_OUT : S_NORM;
      S_NORM: begin
        if (sts_i.norm_done) state_d = S_DIV;
        else cmd_o.norm_step = 1'b1;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.final_sub = 1'b1; state_d = S_REN;
        end else cmd_o.div_step = 1'b1;
      end
      S_REN: begin
        if (sts_i.renorm_done) state_d = S_PACK;
        else cmd_o.renorm_step = 1'b1;
      end
      S_PACK: begin
        cmd_o.pack = 1'b1; state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

/* rtl/core/float64_remainder_fmod_top.sv */
// ----------------------------------------------------------------------------
// float64_remainder_fmod_top
// Exact truncated binary64 remainder (fmod) with dividend sign.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata carries dividend and divisor bit patterns.
// Output stream: m_axis_tdata carries the remainder bit pattern.
// One item at a time: s_axis_tready is high only while the block is idle.
// Special operands (NaN, infinity, zero divisor, |x| <= |y|) go from the
// special check (S_CHK) straight to m_axis_tvalid (S_OUT).
// Otherwise the controller normalizes both significands, then runs the
// restoring division, one step per cycle over the exponent difference,
// then renormalizes and packs the result.
// The result holds on m_axis_tdata while m_axis_tready is low; no new
// item is taken until it is transferred.
// Reset returns the controller to idle and drops any pending result.
// ----------------------------------------------------------------------------
module float64_remainder_fmod_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [63:0] dividend_bits, [127:64] divisor_bits
  input  logic [2*f64_fmod_pkg::DATA_W-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] remainder_bits
  output logic [f64_fmod_pkg::DATA_W-1:0]     m_axis_tdata
);

  f64_fmod_pkg::cmd_t    cmd;
  f64_fmod_pkg::status_t sts;

  f64_fmod_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  f64_fmod_dp u_dp (
    .clk_i,
    .x_i(s_axis_tdata[f64_fmod_pkg::DATA_W-1:0]),
    .y_i(s_axis_tdata[2*f64_fmod_pkg::DATA_W-1:f64_fmod_pkg::DATA_W]),
    .cmd_i(cmd), .sts_o(sts), .res_o(m_axis_tdata)
  );

endmodule

/* rtl/core/f64_fmod_chk.sv */
// ----------------------------------------------------------------------------
// f64_fmod_chk
// Port-level checks for the binary64 remainder block.
// ----------------------------------------------------------------------------
module f64_fmod_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata
);

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("no busy cycle after transfer");

  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after result transfer");

endmodule

bind float64_remainder_fmod_top f64_fmod_chk u_chk (.*);
